FILE: hw/rtl/pqt_pkg.sv
// Package for the point-in-quadrilateral test core.
// Widths, register indexes and the edge table; depends on nothing.
package pqt_pkg;

   localparam int COORD_WIDTH = 24;
   localparam int TAG_WIDTH   = 20;

   localparam int REL_TOL_W = 16;
   localparam int VTX_TOL_W = 12;

   // configuration port
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_REL_TOL = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_VTX_TOL = 1'd1;

   // datapath widths: coordinate difference, product, cross product
   localparam int DIFF_W  = COORD_WIDTH + 1;
   localparam int PROD_W  = 2 * DIFF_W;
   localparam int CROSS_W = PROD_W + 1;
   localparam int PN_W    = CROSS_W + 1;
   localparam int TOL_W   = CROSS_W + REL_TOL_W;
   localparam int CMP_W   = PN_W + REL_TOL_W + 1;

   localparam int NUM_CORNERS = 4;

   typedef logic [1:0] corner_idx_type;

   // edges walked 0-1, 1-3, 3-2, 2-0
   localparam corner_idx_type EDGE_A [NUM_CORNERS] = '{2'd0, 2'd1, 2'd3, 2'd2};
   localparam corner_idx_type EDGE_B [NUM_CORNERS] = '{2'd1, 2'd3, 2'd2, 2'd0};

endpackage

FILE: hw/rtl/point_in_quadrilateral_test_core.sv
// Top level of the point-in-quadrilateral test core: a five stage pipeline.
// Depends on pqt_pkg.
//
// Each request beat carries four corners, a query point and a tag; each response beat carries
// the inside flag and the same tag, in order. One beat enters per clock unless req_stall is
// high. The five register stages are differences, products, cross products, orientation
// fix-up with the tolerance multiply, and the final compare. Every stage has its own valid
// bit and holds only while the stage after it is full and stalled, so bubbles are squeezed
// out and the input keeps flowing while a response waits. Configuration is to be written
// only while the core is idle; the core itself does not enforce this.
module point_in_quadrilateral_test_core (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [pqt_pkg::COORD_WIDTH-1:0] req_corner0_x,
   input  logic signed [pqt_pkg::COORD_WIDTH-1:0] req_corner0_y,
   input  logic signed [pqt_pkg::COORD_WIDTH-1:0] req_corner1_x,
   input  logic signed [pqt_pkg::COORD_WIDTH-1:0] req_corner1_y,
   input  logic signed [pqt_pkg::COORD_WIDTH-1:0] req_corner2_x,
   input  logic signed [pqt_pkg::COORD_WIDTH-1:0] req_corner2_y,
   input  logic signed [pqt_pkg::COORD_WIDTH-1:0] req_corner3_x,
   input  logic signed [pqt_pkg::COORD_WIDTH-1:0] req_corner3_y,
   input  logic signed [pqt_pkg::COORD_WIDTH-1:0] req_point_x,
   input  logic signed [pqt_pkg::COORD_WIDTH-1:0] req_point_y,
   input  logic        [pqt_pkg::TAG_WIDTH-1:0]   req_element_tag,
   // response channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_inside_res,
   output logic        [pqt_pkg::TAG_WIDTH-1:0]   rsp_result_tag,
   // configuration
   input  logic                                  csr_wr_en,
   input  logic        [pqt_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic        [pqt_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import pqt_pkg::*;

   // ---------------------------------------------------------------- config
   logic [REL_TOL_W-1:0] rel_tol_ff;
   logic [VTX_TOL_W-1:0] vtx_tol_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rel_tol_ff <= REL_TOL_W'(1);
         vtx_tol_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_REL_TOL: rel_tol_ff <= csr_wdata[REL_TOL_W-1:0];
            CSR_VTX_TOL: vtx_tol_ff <= csr_wdata[VTX_TOL_W-1:0];
         endcase
      end
   end

   // ---------------------------------------------------------- flow control
   // stage k loads when it is empty or its contents move on
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic rdy1, rdy2, rdy3, rdy4, rdy5;

   assign rdy5 = !v5_ff || !rsp_stall;
   assign rdy4 = !v4_ff || rdy5;
   assign rdy3 = !v3_ff || rdy4;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;

   assign req_stall = !rdy1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req_valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
         if (rdy5) v5_ff <= v4_ff;
      end
   end

   // ------------------------------------------------- stage 1: differences
   logic signed [COORD_WIDTH-1:0] cx [NUM_CORNERS];
   logic signed [COORD_WIDTH-1:0] cy [NUM_CORNERS];

   assign cx[0] = req_corner0_x;
   assign cy[0] = req_corner0_y;
   assign cx[1] = req_corner1_x;
   assign cy[1] = req_corner1_y;
   assign cx[2] = req_corner2_x;
   assign cy[2] = req_corner2_y;
   assign cx[3] = req_corner3_x;
   assign cy[3] = req_corner3_y;

   logic signed [DIFF_W-1:0] dx_in [NUM_CORNERS];
   logic signed [DIFF_W-1:0] dy_in [NUM_CORNERS];
   logic signed [DIFF_W-1:0] dx_ff [NUM_CORNERS];
   logic signed [DIFF_W-1:0] dy_ff [NUM_CORNERS];
   logic signed [DIFF_W-1:0] ox1_ff, oy1_ff, ox2_ff, oy2_ff;
   logic [TAG_WIDTH-1:0]     tag1_ff;

   // point minus each corner
   always_comb begin
      for (int i = 0; i < NUM_CORNERS; i++) begin
         dx_in[i] = DIFF_W'(req_point_x) - DIFF_W'(cx[i]);
         dy_in[i] = DIFF_W'(req_point_y) - DIFF_W'(cy[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         dx_ff   <= dx_in;
         dy_ff   <= dy_in;
         ox1_ff  <= DIFF_W'(req_corner1_x) - DIFF_W'(req_corner0_x);
         oy1_ff  <= DIFF_W'(req_corner1_y) - DIFF_W'(req_corner0_y);
         ox2_ff  <= DIFF_W'(req_corner2_x) - DIFF_W'(req_corner0_x);
         oy2_ff  <= DIFF_W'(req_corner2_y) - DIFF_W'(req_corner0_y);
         tag1_ff <= req_element_tag;
      end
   end

   // ------------------------------------ stage 2: products and corner match
   logic [DIFF_W-1:0] adx [NUM_CORNERS];
   logic [DIFF_W-1:0] ady [NUM_CORNERS];
   logic              match_in;

   always_comb begin
      match_in = 1'b0;
      for (int i = 0; i < NUM_CORNERS; i++) begin
         adx[i] = dx_ff[i][DIFF_W-1] ? DIFF_W'(-dx_ff[i]) : DIFF_W'(dx_ff[i]);
         ady[i] = dy_ff[i][DIFF_W-1] ? DIFF_W'(-dy_ff[i]) : DIFF_W'(dy_ff[i]);
         if (adx[i] <= DIFF_W'(vtx_tol_ff) && ady[i] <= DIFF_W'(vtx_tol_ff))
            match_in = 1'b1;
      end
   end

   logic signed [PROD_W-1:0] po_a_ff, po_b_ff;
   logic signed [PROD_W-1:0] pe_a_ff [NUM_CORNERS];
   logic signed [PROD_W-1:0] pe_b_ff [NUM_CORNERS];
   logic                     match2_ff;
   logic [TAG_WIDTH-1:0]     tag2_ff;

   // edge a-b: (M-A).x * (M-B).y - (M-A).y * (M-B).x
   always_ff @(posedge clock) begin
      if (rdy2) begin
         po_a_ff <= ox1_ff * oy2_ff;
         po_b_ff <= oy1_ff * ox2_ff;
         for (int e = 0; e < NUM_CORNERS; e++) begin
            pe_a_ff[e] <= dx_ff[EDGE_A[e]] * dy_ff[EDGE_B[e]];
            pe_b_ff[e] <= dy_ff[EDGE_A[e]] * dx_ff[EDGE_B[e]];
         end
         match2_ff <= match_in;
         tag2_ff   <= tag1_ff;
      end
   end

   // ------------------------------------------- stage 3: cross products
   logic signed [CROSS_W-1:0] orient3_ff;
   logic signed [CROSS_W-1:0] cross3_ff [NUM_CORNERS];
   logic                      match3_ff;
   logic [TAG_WIDTH-1:0]      tag3_ff;

   always_ff @(posedge clock) begin
      if (rdy3) begin
         orient3_ff <= CROSS_W'(po_a_ff) - CROSS_W'(po_b_ff);
         for (int e = 0; e < NUM_CORNERS; e++)
            cross3_ff[e] <= CROSS_W'(pe_a_ff[e]) - CROSS_W'(pe_b_ff[e]);
         match3_ff <= match2_ff;
         tag3_ff   <= tag2_ff;
      end
   end

   // ----------------------- stage 4: orientation fix-up, tolerance product
   logic                      neg3;
   logic [CROSS_W-1:0]        mag3;

   assign neg3 = orient3_ff[CROSS_W-1];
   assign mag3 = neg3 ? CROSS_W'(-orient3_ff) : CROSS_W'(orient3_ff);

   logic [TOL_W-1:0]       tol4_ff;
   logic signed [PN_W-1:0] pn4_ff [NUM_CORNERS];
   logic                   match4_ff;
   logic [TAG_WIDTH-1:0]   tag4_ff;

   always_ff @(posedge clock) begin
      if (rdy4) begin
         tol4_ff <= TOL_W'(mag3) * TOL_W'(rel_tol_ff);
         for (int e = 0; e < NUM_CORNERS; e++)
            pn4_ff[e] <= neg3 ? -PN_W'(cross3_ff[e]) : PN_W'(cross3_ff[e]);
         match4_ff <= match3_ff;
         tag4_ff   <= tag3_ff;
      end
   end

   // --------------------- stage 5: p * 2^16 + |orient| * tol > 0 per edge
   logic signed [CMP_W-1:0] sum4 [NUM_CORNERS];
   logic [NUM_CORNERS-1:0]  pass4;

   always_comb begin
      for (int e = 0; e < NUM_CORNERS; e++) begin
         sum4[e]  = CMP_W'(signed'({pn4_ff[e], {REL_TOL_W{1'b0}}}))
                    + signed'(CMP_W'(tol4_ff));
         pass4[e] = !sum4[e][CMP_W-1] && (sum4[e] != '0);
      end
   end

   logic                 inside_ff;
   logic [TAG_WIDTH-1:0] tag5_ff;

   always_ff @(posedge clock) begin
      if (rdy5) begin
         inside_ff <= match4_ff || (&pass4);
         tag5_ff   <= tag4_ff;
      end
   end

   assign rsp_valid      = v5_ff;
   assign rsp_inside_res = inside_ff;
   assign rsp_result_tag = tag5_ff;

`ifndef SYNTHESIS
   // an empty pipe never pushes back on the request side
   assert property (@(posedge clock) disable iff (reset)
      (!v1_ff && !v2_ff && !v3_ff && !v4_ff && !v5_ff) |-> !req_stall)
      else $error("request stalled with an empty pipeline");

   // a corner match always ends up as an inside response
   assert property (@(posedge clock) disable iff (reset)
      (rdy5 && v4_ff && match4_ff) |=> (rsp_valid && rsp_inside_res))
      else $error("corner match lost on the way to the response");

   // a held middle stage keeps its beat
   assert property (@(posedge clock) disable iff (reset)
      (v3_ff && !rdy3) |=> (v3_ff && $stable(orient3_ff) && $stable(tag3_ff)))
      else $error("stage 3 beat changed while held");
`endif

endmodule
